/* rtl/core/tlp_pkg.sv */
package tlp_pkg;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_HOLD   = 2'd3
    } phase_t;

    typedef struct packed {
        logic   valid;
        phase_t phase;
    } ctl_t;

    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_START_X  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_Y  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_Z  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GOAL_X   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_GOAL_Y   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_GOAL_Z   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_DURATION = 3'd6;

    localparam int DUR_RESET = 1000000;

endpackage

/* rtl/core/trapezoid_line_profile_unit.sv */
// Trapezoidal velocity profile for a straight three-axis move.
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// block is idle: start point, goal point and move duration.
// Each input transfer carries an elapsed time; each output transfer carries
// the x, y and z positions and the phase of the profile for that time.
// The pipeline takes one transfer in every cycle unless out_stall holds it.
// A result passes through the front stages, the axis multiplier registers,
// the divider and the output register. The restoring divider is a row of
// POS_BITS + 3 cells per axis that resolve one quotient bit each.
// When the receiver raises out_stall while a result is shown, the whole
// pipeline holds and in_stall rises in the same cycle; no result is lost.
// Reset clears all pipeline valid bits and sets the start and goal points to
// zero and the duration to one second.
module trapezoid_line_profile_unit #(
    parameter int TIME_BITS = 24,
    parameter int POS_BITS  = 21
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tlp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [(TIME_BITS > POS_BITS ? TIME_BITS : POS_BITS)-1:0] cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [TIME_BITS-1:0]                 elapsed,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [POS_BITS-1:0]           pos_x,
    output logic signed [POS_BITS-1:0]           pos_y,
    output logic signed [POS_BITS-1:0]           pos_z,
    output logic [1:0]                           phase
);
    import tlp_pkg::*;

    localparam int TB = TIME_BITS;
    localparam int PB = POS_BITS;
    localparam int NW = 2 * TB + 5;
    localparam int DW = 2 * TB;
    localparam int QB = PB + 3;
    localparam int AL = QB + 2;

    logic signed [PB-1:0] start_x_reg, start_y_reg, start_z_reg;
    logic signed [PB-1:0] goal_x_reg, goal_y_reg, goal_z_reg;
    logic [TB-1:0]        dur_reg;

    logic          adv;
    logic          accept;
    ctl_t          front_ctl;
    logic [NW-1:0] num;
    logic [DW-1:0] den;
    ctl_t          ctl_reg [AL];

    logic [PB-1:0] px, py, pz;

    logic                 out_valid_reg;
    logic signed [PB-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    phase_t               phase_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_z_reg <= '0;
            goal_x_reg  <= '0;
            goal_y_reg  <= '0;
            goal_z_reg  <= '0;
            dur_reg     <= TB'(DUR_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_X:  start_x_reg <= cfg_data[PB-1:0];
                REG_START_Y:  start_y_reg <= cfg_data[PB-1:0];
                REG_START_Z:  start_z_reg <= cfg_data[PB-1:0];
                REG_GOAL_X:   goal_x_reg  <= cfg_data[PB-1:0];
                REG_GOAL_Y:   goal_y_reg  <= cfg_data[PB-1:0];
                REG_GOAL_Z:   goal_z_reg  <= cfg_data[PB-1:0];
                REG_DURATION: dur_reg     <= cfg_data[TB-1:0];
                default:      ;
            endcase
        end
    end

    tlp_front #(
        .TB(TB),
        .NW(NW),
        .DW(DW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .accept   (accept),
        .elapsed  (elapsed),
        .duration (dur_reg),
        .ctl      (front_ctl),
        .num      (num),
        .den      (den)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AL; i++)
            begin
                ctl_reg[i] <= '{valid: 1'b0, phase: PH_HOLD};
            end
        end
        else if (adv)
        begin
            ctl_reg[0] <= front_ctl;
            for (int i = 1; i < AL; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    tlp_axis #(.PB(PB), .NW(NW), .DW(DW), .QB(QB)) u_axis_x (
        .clk        (clk),
        .adv        (adv),
        .start      (start_x_reg),
        .goal       (goal_x_reg),
        .num        (num),
        .den        (den),
        .exit_phase (ctl_reg[AL-1].phase),
        .pos        (px)
    );

    tlp_axis #(.PB(PB), .NW(NW), .DW(DW), .QB(QB)) u_axis_y (
        .clk        (clk),
        .adv        (adv),
        .start      (start_y_reg),
        .goal       (goal_y_reg),
        .num        (num),
        .den        (den),
        .exit_phase (ctl_reg[AL-1].phase),
        .pos        (py)
    );

    tlp_axis #(.PB(PB), .NW(NW), .DW(DW), .QB(QB)) u_axis_z (
        .clk        (clk),
        .adv        (adv),
        .start      (start_z_reg),
        .goal       (goal_z_reg),
        .num        (num),
        .den        (den),
        .exit_phase (ctl_reg[AL-1].phase),
        .pos        (pz)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ctl_reg[AL-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && ctl_reg[AL-1].valid)
        begin
            pos_x_reg <= px;
            pos_y_reg <= py;
            pos_z_reg <= pz;
            phase_reg <= ctl_reg[AL-1].phase;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign phase     = phase_reg;

endmodule

/* rtl/core/tlp_front.sv */
module tlp_front #(
    parameter int TB = 24,
    parameter int NW = 2 * TB + 5,
    parameter int DW = 2 * TB
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            accept,
    input  logic [TB-1:0]   elapsed,
    input  logic [TB-1:0]   duration,
    output tlp_pkg::ctl_t   ctl,
    output logic [NW-1:0]   num,
    output logic [DW-1:0]   den
);
    import tlp_pkg::*;

    logic [TB+2:0] e5;
    logic [TB+2:0] t4;
    logic          t_zero;
    phase_t        ph_next;
    logic [TB-1:0] tsel_next;
    logic [TB+3:0] num1_next;

    ctl_t          ctl1_reg;
    logic [TB-1:0] tsel_reg;
    logic [TB+3:0] num1_1_reg;

    ctl_t          ctl2_reg;
    logic [DW-1:0] sq_reg;
    logic [DW-1:0] tt_reg;
    logic [TB+3:0] num1_2_reg;
    logic [TB-1:0] t2_reg;

    ctl_t          ctl3_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [NW-1:0] num_next;
    logic [DW-1:0] den_next;

    always_comb
    begin
        e5        = {elapsed, 2'b00} + (TB+3)'(elapsed);
        t4        = (TB+3)'({duration, 2'b00});
        t_zero    = (duration == '0);
        num1_next = (TB+4)'({elapsed, 3'b000}) + (TB+4)'({elapsed, 1'b0})
                    - (TB+4)'(duration);
        if (t_zero || elapsed >= duration)
        begin
            ph_next = PH_HOLD;
        end
        else if (e5 <= (TB+3)'(duration))
        begin
            ph_next = PH_ACCEL;
        end
        else if (e5 <= t4)
        begin
            ph_next = PH_CRUISE;
        end
        else
        begin
            ph_next = PH_DECEL;
        end
        tsel_next = (ph_next == PH_DECEL) ? (duration - elapsed) : elapsed;
    end

    always_comb
    begin
        num_next = (NW)'({sq_reg, 4'b0000}) + (NW)'({sq_reg, 3'b000}) + (NW)'(sq_reg);
        den_next = tt_reg;
        if (ctl2_reg.phase == PH_CRUISE)
        begin
            num_next = (NW)'(num1_2_reg);
            den_next = (DW)'(t2_reg);
        end
        else if (ctl2_reg.phase == PH_HOLD)
        begin
            num_next = '0;
            den_next = (DW)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '{valid: 1'b0, phase: PH_HOLD};
            ctl2_reg <= '{valid: 1'b0, phase: PH_HOLD};
            ctl3_reg <= '{valid: 1'b0, phase: PH_HOLD};
        end
        else if (adv)
        begin
            ctl1_reg <= '{valid: accept, phase: ph_next};
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tsel_reg   <= tsel_next;
            num1_1_reg <= num1_next;
            sq_reg     <= tsel_reg * tsel_reg;
            tt_reg     <= duration * duration;
            t2_reg     <= duration;
            num1_2_reg <= num1_1_reg;
            num_reg    <= num_next;
            den_reg    <= den_next;
        end
    end

    assign ctl = ctl3_reg;
    assign num = num_reg;
    assign den = den_reg;

endmodule

/* rtl/core/tlp_cell.sv */
module tlp_cell #(
    parameter int DW = 48,
    parameter int QB = 24
) (
    input  logic          clk,
    input  logic          adv,
    input  logic [DW-1:0] r_in,
    input  logic [QB-1:0] feed_in,
    input  logic [QB-1:0] q_in,
    input  logic [DW-1:0] den_in,
    output logic [DW-1:0] r_out,
    output logic [QB-1:0] feed_out,
    output logic [QB-1:0] q_out,
    output logic [DW-1:0] den_out
);
    logic [DW:0]   rr;
    logic          take;
    logic [DW-1:0] r_next;
    logic [DW-1:0] r_reg;
    logic [QB-1:0] feed_reg;
    logic [QB-1:0] q_reg;
    logic [DW-1:0] den_reg;

    always_comb
    begin
        rr     = {r_in, feed_in[QB-1]};
        take   = (rr >= {1'b0, den_in});
        r_next = take ? DW'(rr - {1'b0, den_in}) : DW'(rr);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg    <= r_next;
            feed_reg <= {feed_in[QB-2:0], 1'b0};
            q_reg    <= {q_in[QB-2:0], take};
            den_reg  <= den_in;
        end
    end

    assign r_out    = r_reg;
    assign feed_out = feed_reg;
    assign q_out    = q_reg;
    assign den_out  = den_reg;

endmodule

/* rtl/core/tlp_axis.sv */
module tlp_axis #(
    parameter int PB = 21,
    parameter int NW = 53,
    parameter int DW = 48,
    parameter int QB = PB + 3
) (
    input  logic                 clk,
    input  logic                 adv,
    input  logic signed [PB-1:0] start,
    input  logic signed [PB-1:0] goal,
    input  logic [NW-1:0]        num,
    input  logic [DW-1:0]        den,
    input  tlp_pkg::phase_t      exit_phase,
    output logic [PB-1:0]        pos
);
    import tlp_pkg::*;

    localparam int NL = NW / 2;
    localparam int NH = NW - NL;
    localparam int PW = PB + NW;

    logic [PB:0]   d;
    logic [PB-1:0] mag_reg;
    logic          neg_reg;

    logic [PB+NL-1:0] pl_reg;
    logic [PB+NH-1:0] ph_reg;
    logic [DW-1:0]    den1_reg;
    logic [PW-1:0]    prod_reg;
    logic [DW-1:0]    den2_reg;

    logic [DW-1:0] r_w    [QB+1];
    logic [QB-1:0] feed_w [QB+1];
    logic [QB-1:0] q_w    [QB+1];
    logic [DW-1:0] den_w  [QB+1];

    logic [PB:0] off_ext;
    logic [PB:0] soff;
    logic [PB:0] sum;

    assign d = {goal[PB-1], goal} - {start[PB-1], start};

    always_ff @(posedge clk)
    begin
        neg_reg <= d[PB];
        mag_reg <= d[PB] ? PB'(-d) : d[PB-1:0];
        if (adv)
        begin
            pl_reg   <= mag_reg * num[NL-1:0];
            ph_reg   <= mag_reg * num[NW-1:NL];
            den1_reg <= den;
            prod_reg <= PW'(pl_reg) + PW'({ph_reg, {NL{1'b0}}});
            den2_reg <= den1_reg;
        end
    end

    assign r_w[0]    = prod_reg[QB+DW-1:QB];
    assign feed_w[0] = prod_reg[QB-1:0];
    assign q_w[0]    = '0;
    assign den_w[0]  = den2_reg;

    for (genvar k = 0; k < QB; k++)
    begin : g_cell
        tlp_cell #(
            .DW(DW),
            .QB(QB)
        ) u_cell (
            .clk      (clk),
            .adv      (adv),
            .r_in     (r_w[k]),
            .feed_in  (feed_w[k]),
            .q_in     (q_w[k]),
            .den_in   (den_w[k]),
            .r_out    (r_w[k+1]),
            .feed_out (feed_w[k+1]),
            .q_out    (q_w[k+1]),
            .den_out  (den_w[k+1])
        );
    end

    always_comb
    begin
        off_ext = {1'b0, q_w[QB][QB-1:3]};
        soff    = neg_reg ? (PB+1)'(-off_ext) : off_ext;
        if (exit_phase == PH_HOLD)
        begin
            sum = {goal[PB-1], goal};
        end
        else if (exit_phase == PH_DECEL)
        begin
            sum = {goal[PB-1], goal} - soff;
        end
        else
        begin
            sum = {start[PB-1], start} + soff;
        end
    end

    assign pos = sum[PB-1:0];

endmodule

/* test/tb_trapezoid_line_profile_unit.sv */
module tb_trapezoid_line_profile_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tlp_pkg::*;

    localparam int TB = 24;
    localparam int PB = 21;
    localparam int LATENCY_WAIT = 60;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic signed [PB-1:0] x;
        logic signed [PB-1:0] y;
        logic signed [PB-1:0] z;
        phase_t ph;
    } position_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [TB-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [TB-1:0] elapsed;
    logic out_valid;
    logic out_stall;
    logic signed [PB-1:0] pos_x;
    logic signed [PB-1:0] pos_y;
    logic signed [PB-1:0] pos_z;
    logic [1:0] phase;

    trapezoid_line_profile_unit u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .elapsed(elapsed), .out_valid(out_valid), .out_stall(out_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .phase(phase)
    );

    logic signed [PB-1:0] start_pt [3];
    logic signed [PB-1:0] goal_pt [3];
    logic [TB-1:0] cur_duration;

    logic [TB-1:0] pending_times [$];
    position_t expected_positions [$];
    int idle_pct = 0;
    int stall_pct = 0;
    logic hold_all = 1'b0;
    int errors = 0;
    int cycles = 0;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic signed [PB-1:0] axis_position(logic signed [PB-1:0] s,
            logic signed [PB-1:0] g, phase_t ph, logic [127:0] num, logic [127:0] den);
        longint d;
        logic [127:0] mag;
        logic [127:0] q;
        longint off;
        longint p;
        d = longint'(g) - longint'(s);
        mag = (d < 0) ? 128'(-d) : 128'(d);
        if (ph == PH_HOLD)
            return g;
        q = (mag * num) / den;
        off = longint'(q >> 3);
        if (d < 0)
            off = -off;
        p = (ph == PH_DECEL) ? longint'(g) - off : longint'(s) + off;
        return p[PB-1:0];
    endfunction

    function automatic position_t profile_at(logic [TB-1:0] e);
        position_t r;
        logic [127:0] t;
        logic [127:0] ee;
        logic [127:0] num;
        logic [127:0] den;
        t = 128'(cur_duration);
        ee = 128'(e);
        num = 0;
        den = 1;
        if (t == 0 || ee >= t)
            r.ph = PH_HOLD;
        else if (5 * ee <= t)
        begin
            r.ph = PH_ACCEL;
            num = 25 * ee * ee;
            den = t * t;
        end
        else if (5 * ee <= 4 * t)
        begin
            r.ph = PH_CRUISE;
            num = 10 * ee - t;
            den = t;
        end
        else
        begin
            r.ph = PH_DECEL;
            num = 25 * (t - ee) * (t - ee);
            den = t * t;
        end
        r.x = axis_position(start_pt[0], goal_pt[0], r.ph, num, den);
        r.y = axis_position(start_pt[1], goal_pt[1], r.ph, num, den);
        r.z = axis_position(start_pt[2], goal_pt[2], r.ph, num, den);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            elapsed <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_positions.insert(expected_positions.size(), profile_at(elapsed));
            if (!in_valid || !in_stall)
            begin
                if (pending_times.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    elapsed <= pending_times.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        position_t exp_pos;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_positions.size() == 0)
                begin
                    $error("unexpected result transfer: pos_x %0d phase %0d", pos_x, phase);
                    errors++;
                end
                else
                begin
                    exp_pos = expected_positions.pop_front();
                    if (pos_x !== exp_pos.x)
                    begin
                        $error("pos_x expected %0d actual %0d", exp_pos.x, pos_x);
                        errors++;
                    end
                    if (pos_y !== exp_pos.y)
                    begin
                        $error("pos_y expected %0d actual %0d", exp_pos.y, pos_y);
                        errors++;
                    end
                    if (pos_z !== exp_pos.z)
                    begin
                        $error("pos_z expected %0d actual %0d", exp_pos.z, pos_z);
                        errors++;
                    end
                    if (phase !== exp_pos.ph)
                    begin
                        $error("phase expected %0d actual %0d", exp_pos.ph, phase);
                        errors++;
                    end
                end
            end
            out_stall <= hold_all || ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("trapezoid_line_profile_unit: mismatch");
            $finish;
        end
    end

    task automatic queue_time(logic [TB-1:0] value);
        pending_times.insert(pending_times.size(), value);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [TB-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == REG_DURATION)
            cur_duration = value;
        else if (idx < REG_GOAL_X)
            start_pt[idx] = value[PB-1:0];
        else
            goal_pt[idx - REG_GOAL_X] = value[PB-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_move(int sx, int sy, int sz, int gx, int gy, int gz, int t);
        write_reg(REG_START_X, TB'(sx));
        write_reg(REG_START_Y, TB'(sy));
        write_reg(REG_START_Z, TB'(sz));
        write_reg(REG_GOAL_X, TB'(gx));
        write_reg(REG_GOAL_Y, TB'(gy));
        write_reg(REG_GOAL_Z, TB'(gz));
        write_reg(REG_DURATION, TB'(t));
    endtask

    task automatic wait_drained();
        while (pending_times.size() > 0 || in_valid || expected_positions.size() > 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    task automatic add_boundaries();
        logic [TB-1:0] t;
        t = cur_duration;
        queue_time('0);
        queue_time(t / 5);
        queue_time(t / 5 + 1);
        queue_time(TB'((4 * 48'(t)) / 5));
        queue_time(TB'((4 * 48'(t)) / 5 + 1));
        queue_time(t - 1);
        queue_time(t);
        queue_time('1);
    endtask

    task automatic add_random(int n);
        int hi;
        for (int i = 0; i < n; i++)
        begin
            hi = (cur_duration > 24'hE00000) ? 24'hFFFFFF
                                             : cur_duration + cur_duration / 8 + 2;
            if ($urandom_range(99) < 75)
                queue_time(TB'($urandom_range(hi, 0)));
            else
                queue_time(TB'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start_pt = '{0, 0, 0};
        goal_pt = '{0, 0, 0};
        cur_duration = DUR_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        add_boundaries();
        wait_drained();

        set_move(-1048576, 1048575, 0, 1048575, -1048576, 17, 16777215);
        add_boundaries();
        queue_time(24'h555555);
        queue_time(24'hAAAAAA);
        add_random(150);
        wait_drained();

        set_move(1000, -2000, 300000, -5000, 7000, -300000, 1000);
        idle_pct = 79;
        add_boundaries();
        add_random(150);
        wait_drained();

        set_move(-1048576, -1048576, 1048575, 1048575, 1048575, -1048576, 5);
        idle_pct = 0;
        stall_pct = 79;
        add_boundaries();
        add_random(120);
        wait_drained();

        set_move($urandom_range(2000000), 12345, -777, -99999, 54321, 1048575, 3);
        idle_pct = 32;
        stall_pct = 32;
        add_random(60);
        wait_drained();

        set_move(500, -500, 0, 400, -400, 0, 0);
        add_random(40);
        wait_drained();

        set_move(-300000, 200000, 1, 800000, -900000, -1, 250000);
        idle_pct = 0;
        stall_pct = 0;
        fork
            begin
                hold_all <= 1'b1;
                repeat (300) @(posedge clk);
                hold_all <= 1'b0;
            end
        join_none
        add_random(200);
        wait_drained();
        add_random(100);
        wait_drained();

        set_move(-1048576, 1048575, -20, 1048575, -1048576, 20, 1);
        add_random(40);
        wait_drained();

        set_move($urandom_range(2097151) - 1048576, $urandom_range(2097151) - 1048576,
                 $urandom_range(2097151) - 1048576, $urandom_range(2097151) - 1048576,
                 $urandom_range(2097151) - 1048576, $urandom_range(2097151) - 1048576,
                 $urandom_range(16777215, 5));
        idle_pct = 32;
        stall_pct = 32;
        add_random(150);
        wait_drained();

        if (errors == 0)
            $display("trapezoid_line_profile_unit: match");
        else
            $display("trapezoid_line_profile_unit: mismatch");
        $finish;
    end
endmodule

/* sim.f */
rtl/core/tlp_pkg.sv
rtl/core/tlp_front.sv
rtl/core/tlp_cell.sv
rtl/core/tlp_axis.sv
rtl/core/trapezoid_line_profile_unit.sv
test/tb_trapezoid_line_profile_unit.sv
